### hw/rtl/lcdw_pkg.sv
// ----------------------------------------------------------------------------
// lcdw_pkg: shared types and codes for the segment-LCD serial frame writer
// Request codes, register indexes and the job record passed from front to back.
// ----------------------------------------------------------------------------
package lcdw_pkg;

  // request codes on func
  localparam logic [1:0] FUNC_CMD   = 2'd0;
  localparam logic [1:0] FUNC_OPEN  = 2'd1;
  localparam logic [1:0] FUNC_DATA  = 2'd2;
  localparam logic [1:0] FUNC_CLOSE = 2'd3;

  // configuration register indexes
  localparam logic REG_COMMAND_ID = 1'b0;
  localparam logic REG_WRITE_ID   = 1'b1;

  localparam int ID_W   = 3;
  localparam int ADDR_W = 6;
  localparam int BYTE_W = 8;

  localparam logic [ID_W-1:0] COMMAND_ID_RST = 3'd4;
  localparam logic [ID_W-1:0] WRITE_ID_RST   = 3'd5;

  // longest run of clocked bits in one job: id, command byte, zero bit
  localparam int WORD_W = ID_W + BYTE_W + 1;
  localparam int CNT_W  = $clog2(WORD_W + 1);

  // job queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // one job: optional leading release, MSB-first bits, optional trailing release
  typedef struct packed {
    logic              rel_first;
    logic [WORD_W-1:0] word;
    logic [CNT_W-1:0]  nbits;
    logic              rel_last;
  } job_t;

endpackage

### hw/rtl/lcdw_front.sv
// ----------------------------------------------------------------------------
// lcdw_front: request decoder
// Holds the id registers and the frame-open flag, turns each request into a
// job record and drops requests that give no result.
// ----------------------------------------------------------------------------
module lcdw_front
  import lcdw_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_addr,
  input  logic [ID_W-1:0]  cfg_data,
  input  logic             push,
  input  logic [1:0]       func,
  input  logic [BYTE_W-1:0] value,
  input  logic             q_full,
  output logic             q_wr,
  output job_t             q_job
);

  logic [ID_W-1:0] command_id;
  logic [ID_W-1:0] write_id;
  logic            frame_open;
  logic            frame_open_next;
  logic            accept;
  logic            has_result;
  logic [BYTE_W-1:0] value_rev;

  assign accept = push && !q_full;

  always_comb begin
    for (int i = 0; i < BYTE_W; i++) begin
      value_rev[i] = value[BYTE_W-1-i];
    end
  end

  always_comb begin
    q_job           = '0;
    has_result      = 1'b0;
    frame_open_next = frame_open;
    case (func)
      FUNC_CMD: begin
        q_job.rel_first = frame_open;
        q_job.word      = {command_id, value, 1'b0};
        q_job.nbits     = CNT_W'(WORD_W);
        q_job.rel_last  = 1'b1;
        has_result      = 1'b1;
        frame_open_next = 1'b0;
      end
      FUNC_OPEN: begin
        q_job.rel_first = frame_open;
        q_job.word      = {write_id, value[ADDR_W-1:0], {(WORD_W-ID_W-ADDR_W){1'b0}}};
        q_job.nbits     = CNT_W'(ID_W + ADDR_W);
        has_result      = 1'b1;
        frame_open_next = 1'b1;
      end
      FUNC_DATA: begin
        // data goes out LSB first: reverse so the back always shifts MSB first
        q_job.word  = {value_rev, {(WORD_W-BYTE_W){1'b0}}};
        q_job.nbits = CNT_W'(BYTE_W);
        has_result  = frame_open;
      end
      default: begin
        q_job.rel_first = 1'b1;
        has_result      = frame_open;
        frame_open_next = 1'b0;
      end
    endcase
  end

  assign q_wr = accept && has_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      command_id <= COMMAND_ID_RST;
      write_id   <= WRITE_ID_RST;
      frame_open <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == REG_COMMAND_ID) begin
          command_id <= cfg_data;
        end else begin
          write_id <= cfg_data;
        end
      end
      if (accept) begin
        frame_open <= frame_open_next;
      end
    end
  end

  // stray data never reaches the back
  a_drop_data: assert property (@(posedge clk) disable iff (rst)
    (accept && func == FUNC_DATA && !frame_open) |-> !q_wr)
    else $error("data item queued with no frame open");

endmodule

### hw/rtl/lcdw_job_queue.sv
// ----------------------------------------------------------------------------
// lcdw_job_queue: small job queue between request decoder and serializer
// Register-based queue, one write and one read per cycle; writes are held off while full and reads while empty.
// ----------------------------------------------------------------------------
module lcdw_job_queue
  import lcdw_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  job_t wr_job,
  input  logic rd,
  output job_t rd_job,
  output logic full,
  output logic q_empty
);

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;
  logic              do_wr;
  logic              do_rd;

  assign full    = (count == QCNT_W'(QDEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !q_empty;
  assign rd_job  = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(wr && full))
    else $error("job queue written while full");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("job queue count out of range");

endmodule

### hw/rtl/lcdw_back.sv
// ----------------------------------------------------------------------------
// lcdw_back: serializer
// Takes one job at a time and emits one result per cycle into an output
// register that is read as a queue head, while that register is empty or popped.
// ----------------------------------------------------------------------------
module lcdw_back
  import lcdw_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  job_t q_job,
  input  logic q_empty,
  output logic q_rd,
  input  logic pop,
  output logic empty,
  output logic kind,
  output logic data_bit,
  output logic last
);

  logic              busy;
  logic              rel_first;
  logic [WORD_W-1:0] word;
  logic [CNT_W-1:0]  cnt;
  logic              rel_last;

  logic out_valid;
  logic advance;
  logic emit;
  logic e_kind;
  logic e_bit;
  logic e_last;

  assign advance = !out_valid || pop;
  assign emit    = busy && advance;
  assign empty   = !out_valid;

  // next result from the current job
  always_comb begin
    if (rel_first) begin
      e_kind = 1'b1;
      e_bit  = 1'b0;
      e_last = (cnt == '0) && !rel_last;
    end else if (cnt != '0) begin
      e_kind = 1'b0;
      e_bit  = word[WORD_W-1];
      e_last = (cnt == CNT_W'(1)) && !rel_last;
    end else begin
      e_kind = 1'b1;
      e_bit  = 1'b0;
      e_last = 1'b1;
    end
  end

  // load a new job when idle or as the current one gives its last result
  assign q_rd = (!busy || (emit && e_last)) && !q_empty;

  always_ff @(posedge clk) begin
    if (q_rd) begin
      rel_first <= q_job.rel_first;
      word      <= q_job.word;
      cnt       <= q_job.nbits;
      rel_last  <= q_job.rel_last;
    end else if (emit) begin
      if (rel_first) begin
        rel_first <= 1'b0;
      end else if (cnt != '0) begin
        word <= {word[WORD_W-2:0], 1'b0};
        cnt  <= cnt - 1'b1;
      end else begin
        rel_last <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind     <= e_kind;
      data_bit <= e_bit;
      last     <= e_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_rd) begin
        busy <= 1'b1;
      end else if (emit && e_last) begin
        busy <= 1'b0;
      end
      if (advance) begin
        out_valid <= emit;
      end
    end
  end

  a_busy_has_work: assert property (@(posedge clk) disable iff (rst)
    busy |-> (rel_first || cnt != '0 || rel_last))
    else $error("serializer busy with an empty job");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt <= CNT_W'(WORD_W))
    else $error("serializer bit count out of range");

  a_release_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind) |-> !data_bit)
    else $error("release result with data bit set");

endmodule

### hw/rtl/segment_lcd_serial_frame_writer.sv
// ----------------------------------------------------------------------------
// segment_lcd_serial_frame_writer: three-wire segment-LCD write serializer
// An accepted item goes through the job queue and the serializer's job registers
// to the output register on the result ports. One result per cycle while that
// register is empty or popped, up to 14 per item; the one-bit shift sets the rate.
// A four-job queue lets requests enter while earlier frames still shift out.
// Reset (rst, synchronous): ids back to 4 and 5, no frame open, queues empty.
// ----------------------------------------------------------------------------
module segment_lcd_serial_frame_writer
  import lcdw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_addr,
  input  logic [ID_W-1:0]   cfg_data,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        func,
  input  logic [BYTE_W-1:0] value,
  output logic              empty,
  input  logic              pop,
  output logic              kind,
  output logic              data_bit,
  output logic              last
);

  logic q_wr;
  logic q_rd;
  logic q_empty;
  job_t wr_job;
  job_t rd_job;

  lcdw_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .push     (push),
    .func     (func),
    .value    (value),
    .q_full   (full),
    .q_wr     (q_wr),
    .q_job    (wr_job)
  );

  lcdw_job_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_job  (wr_job),
    .rd      (q_rd),
    .rd_job  (rd_job),
    .full    (full),
    .q_empty (q_empty)
  );

  lcdw_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_job    (rd_job),
    .q_empty  (q_empty),
    .q_rd     (q_rd),
    .pop      (pop),
    .empty    (empty),
    .kind     (kind),
    .data_bit (data_bit),
    .last     (last)
  );

endmodule

### dv/segment_lcd_serial_frame_writer_test.sv
// ----------------------------------------------------------------------------
// segment_lcd_serial_frame_writer_test: serial frame writer testbench
// Drives command, open, data and close requests through the push/full side.
// A local frame-state predictor expands each accepted item into its bit and
// release results, and every popped result is checked against the oldest one.
// The sender runs in random bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module segment_lcd_serial_frame_writer_test;
  import lcdw_pkg::*;

  localparam logic KIND_BIT     = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;
  localparam int   SETTLE_CYCLES = 24;     // margin after the last expected result is popped
  localparam int   RUN_LIMIT     = 3000000;
  localparam int   MAX_REPORTS   = 10;

  typedef struct packed {
    logic kind;
    logic data_bit;
    logic last;
  } lcd_result_t;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic              cfg_addr;
  logic [ID_W-1:0]   cfg_data;
  logic              push;
  logic              full;
  logic [1:0]        func;
  logic [BYTE_W-1:0] value;
  logic              empty;
  logic              pop;
  logic              kind;
  logic              data_bit;
  logic              last;

  // predictor state
  logic [ID_W-1:0] cmd_id_cfg;
  logic [ID_W-1:0] wr_id_cfg;
  logic            line_open;
  lcd_result_t     pending_bits[$];

  int mismatches;
  int items_sent;
  int items_ignored;
  int results_seen;
  int releases_seen;
  int full_stall_cycles;
  int reg_writes;

  // receiver controls
  int stall_style;
  int hold_req;

  segment_lcd_serial_frame_writer dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .push     (push),
    .full     (full),
    .func     (func),
    .value    (value),
    .empty    (empty),
    .pop      (pop),
    .kind     (kind),
    .data_bit (data_bit),
    .last     (last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT);
    $display("tb: failure");
    $finish;
  end

  function automatic lcd_result_t mk_result(input logic k, input logic b);
    lcd_result_t r;
    r.kind = k;
    r.data_bit = b;
    r.last = 1'b0;
    return r;
  endfunction

  // Expand one accepted request into its results; returns how many.
  function automatic int expand_request(input logic [1:0] f, input logic [BYTE_W-1:0] v);
    lcd_result_t seq[$];
    case (f)
      FUNC_CMD: begin
        if (line_open) seq.push_back(mk_result(KIND_RELEASE, 1'b0));
        line_open = 1'b0;
        for (int i = ID_W - 1; i >= 0; i--) seq.push_back(mk_result(KIND_BIT, cmd_id_cfg[i]));
        for (int i = BYTE_W - 1; i >= 0; i--) seq.push_back(mk_result(KIND_BIT, v[i]));
        seq.push_back(mk_result(KIND_BIT, 1'b0));
        seq.push_back(mk_result(KIND_RELEASE, 1'b0));
      end
      FUNC_OPEN: begin
        if (line_open) seq.push_back(mk_result(KIND_RELEASE, 1'b0));
        for (int i = ID_W - 1; i >= 0; i--) seq.push_back(mk_result(KIND_BIT, wr_id_cfg[i]));
        for (int i = ADDR_W - 1; i >= 0; i--) seq.push_back(mk_result(KIND_BIT, v[i]));
        line_open = 1'b1;
      end
      FUNC_DATA: begin
        // data bytes go out LSB first, only inside an open frame
        if (line_open)
          for (int i = 0; i < BYTE_W; i++) seq.push_back(mk_result(KIND_BIT, v[i]));
      end
      default: begin
        if (line_open) seq.push_back(mk_result(KIND_RELEASE, 1'b0));
        line_open = 1'b0;
      end
    endcase
    if (seq.size() > 0) seq[seq.size() - 1].last = 1'b1;
    foreach (seq[i]) pending_bits.push_back(seq[i]);
    return seq.size();
  endfunction

  // Offer one item; push stays high afterwards so bursts run back to back.
  task automatic send_item(input logic [1:0] f, input logic [BYTE_W-1:0] v);
    int n;
    @(negedge clk);
    push  <= 1'b1;
    func  <= f;
    value <= v;
    @(posedge clk);
    while (full) begin
      full_stall_cycles++;
      @(posedge clk);
    end
    n = expand_request(f, v);
    items_sent++;
    if (n == 0) items_ignored++;
  endtask

  int burst_left;

  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        @(negedge clk);
        push <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
  endtask

  task automatic send_paced(input logic [1:0] f, input logic [BYTE_W-1:0] v);
    send_item(f, v);
    pace();
  endtask

  // Stop offering and wait until every expected result has been popped.
  task automatic wait_idle();
    @(negedge clk);
    push <= 1'b0;
    while (pending_bits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [ID_W-1:0] d);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= d;
    @(posedge clk);
    if (idx == REG_COMMAND_ID) cmd_id_cfg = d;
    else wr_id_cfg = d;
    reg_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver: long holds on request, otherwise always-pop or a rotating pattern.
  initial begin
    int hold_left;
    int reseed_cnt;
    logic [15:0] pop_pattern;
    pop = 1'b0;
    hold_left = 0;
    reseed_cnt = 0;
    pop_pattern = 16'hffff;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (reseed_cnt == 0) begin
        pop_pattern = $urandom;
        reseed_cnt = $urandom_range(20, 80);
      end else begin
        reseed_cnt--;
        pop_pattern = {pop_pattern[14:0], pop_pattern[15]};
      end
      if (rst) begin
        pop <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (stall_style == 0) begin
        pop <= 1'b1;
      end else begin
        pop <= pop_pattern[0];
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    lcd_result_t exp_r;
    if (!rst && pop && !empty) begin
      results_seen++;
      if (kind == KIND_RELEASE) releases_seen++;
      if (pending_bits.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("error: unexpected result kind=%0d data_bit=%0d last=%0d",
                   kind, data_bit, last);
      end else begin
        exp_r = pending_bits.pop_front();
        if (kind !== exp_r.kind || data_bit !== exp_r.data_bit || last !== exp_r.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("error: result %0d exp k=%0d b=%0d l=%0d, got k=%0d b=%0d l=%0d",
                     results_seen, exp_r.kind, exp_r.data_bit, exp_r.last,
                     kind, data_bit, last);
        end
      end
    end
  end

  // Extremes of the value field, every request code, and the frame corner cases.
  task automatic test_directed_frames();
    stall_style = 0;
    send_paced(FUNC_CMD, 8'h00);
    send_paced(FUNC_CMD, 8'hff);
    send_paced(FUNC_OPEN, 8'h00);
    send_paced(FUNC_DATA, 8'h00);
    send_paced(FUNC_DATA, 8'hff);
    send_paced(FUNC_CLOSE, 8'h00);
    // no frame open: data dropped, close ignored
    send_paced(FUNC_DATA, 8'h5a);
    send_paced(FUNC_CLOSE, 8'hff);
    // address bits 7..6 must not show up
    send_paced(FUNC_OPEN, 8'hff);
    send_paced(FUNC_DATA, 8'ha5);
    // reopen while open: release first
    send_paced(FUNC_OPEN, 8'hc0);
    send_paced(FUNC_DATA, 8'h3c);
    // command while open: release plus a full command frame
    send_paced(FUNC_CMD, 8'ha5);
    send_paced(FUNC_CLOSE, 8'h00);
    send_paced(FUNC_OPEN, 8'h2a);
    send_paced(FUNC_CLOSE, 8'h00);
    send_paced(FUNC_CLOSE, 8'h00);
    wait_idle();
  endtask

  task automatic test_register_settings();
    logic [ID_W-1:0] cmd_set[4];
    logic [ID_W-1:0] wr_set[4];
    cmd_set = '{3'd0, 3'd7, 3'd7, 3'd0};
    wr_set  = '{3'd7, 3'd0, 3'd7, 3'd0};
    stall_style = 1;
    for (int s = 0; s < 4; s++) begin
      wait_idle();
      write_reg(REG_COMMAND_ID, cmd_set[s]);
      write_reg(REG_WRITE_ID, wr_set[s]);
      send_paced(FUNC_CMD, 8'($urandom));
      send_paced(FUNC_OPEN, 8'($urandom));
      send_paced(FUNC_DATA, 8'($urandom));
      send_paced(FUNC_CLOSE, 8'($urandom));
    end
    wait_idle();
  endtask

  // Mostly well-formed frames with random content, some noise in between.
  task automatic test_random_traffic();
    int effective;
    int next_cfg;
    int pick;
    int ndata;
    effective = 0;
    next_cfg = 20;
    while (effective < 60) begin
      if (effective >= next_cfg) begin
        wait_idle();
        write_reg(REG_COMMAND_ID, ID_W'($urandom));
        write_reg(REG_WRITE_ID, ID_W'($urandom));
        stall_style = $urandom_range(0, 3) == 0 ? 0 : 1;
        next_cfg += 20;
      end
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        send_paced(FUNC_OPEN, 8'($urandom));
        effective++;
        ndata = $urandom_range(0, 5);
        repeat (ndata) begin
          send_paced(FUNC_DATA, 8'($urandom));
          effective++;
        end
        // sometimes leave the frame open for the next request to release
        if ($urandom_range(0, 3) != 0) begin
          send_paced(FUNC_CLOSE, 8'($urandom));
          effective++;
        end
      end else if (pick < 7) begin
        send_paced(FUNC_CMD, 8'($urandom));
        effective++;
      end else begin
        send_paced(2'($urandom), 8'($urandom));
        if (pending_bits.size() != 0) effective++;
      end
    end
    wait_idle();
  endtask

  // Receiver holds off long enough to fill the block; sender keeps offering.
  task automatic test_backpressure();
    for (int pass = 0; pass < 2; pass++) begin
      stall_style = pass;
      hold_req = 200;
      send_item(FUNC_OPEN, 8'($urandom));
      repeat (6) send_item(FUNC_DATA, 8'($urandom));
      repeat (6) send_item(FUNC_CMD, 8'($urandom));
      send_item(FUNC_OPEN, 8'($urandom));
      send_item(FUNC_DATA, 8'($urandom));
      send_item(FUNC_CLOSE, 8'($urandom));
      wait_idle();
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_addr = REG_COMMAND_ID;
    cfg_data = '0;
    push = 1'b0;
    func = FUNC_CMD;
    value = '0;
    stall_style = 0;
    hold_req = 0;
    burst_left = 0;
    mismatches = 0;
    items_sent = 0;
    items_ignored = 0;
    results_seen = 0;
    releases_seen = 0;
    full_stall_cycles = 0;
    reg_writes = 0;
    cmd_id_cfg = COMMAND_ID_RST;
    wr_id_cfg = WRITE_ID_RST;
    line_open = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_frames();
    test_register_settings();
    test_backpressure();
    test_random_traffic();
    wait_idle();

    $display("summary: %0d items (%0d gave no result), %0d results, %0d releases",
             items_sent, items_ignored, results_seen, releases_seen);
    $display("summary: %0d register writes, %0d cycles with input held off by full",
             reg_writes, full_stall_cycles);
    if (mismatches == 0 && pending_bits.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/lcdw_pkg.sv
hw/rtl/lcdw_front.sv
hw/rtl/lcdw_job_queue.sv
hw/rtl/lcdw_back.sv
hw/rtl/segment_lcd_serial_frame_writer.sv
dv/segment_lcd_serial_frame_writer_test.sv
